// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the typed integer ALU.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while reset is low.
`define TAI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked at every edge, reset included.
`define TAI_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tai_pkg.sv -----
// Package of the typed integer ALU: codes, widths, the front-to-back record
// and the width fitting function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tai_pkg;

   localparam int DATA_W = 64;
   localparam int CMD_W = 4;
   localparam int TY_W = 3;
   localparam int TGT_W = 4;
   localparam int ERR_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
   localparam logic [CMD_W-1:0] CMD_REM = 4'd4;
   localparam logic [CMD_W-1:0] CMD_AND = 4'd5;
   localparam logic [CMD_W-1:0] CMD_OR = 4'd6;
   localparam logic [CMD_W-1:0] CMD_XOR = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SHL = 4'd8;
   localparam logic [CMD_W-1:0] CMD_SHR = 4'd9;
   localparam logic [CMD_W-1:0] CMD_EQ = 4'd10;
   localparam logic [CMD_W-1:0] CMD_GT = 4'd11;
   localparam logic [CMD_W-1:0] CMD_GE = 4'd12;
   localparam logic [CMD_W-1:0] CMD_NE = 4'd13;
   localparam logic [CMD_W-1:0] CMD_CAST = 4'd14;

   localparam logic [TGT_W-1:0] TGT_PTR = 4'd8;

   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SHIFT = 2'd2;
   localparam logic [ERR_W-1:0] ERR_CAST = 2'd3;

   localparam logic [DATA_W-1:0] CMP_TRUE = 64'h01;
   localparam logic [DATA_W-1:0] CMP_FALSE = 64'h00;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TY_W-1:0]   ty;
      kind_type          kind;
      logic [ERR_W-1:0]  err;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] res;
   } op_type;

   function automatic logic ty_signed(input logic [TY_W-1:0] ty);
      return ~ty[2];
   endfunction

   // Truncate to the type's width and extend by its signedness.
   function automatic logic [DATA_W-1:0] fit(input logic [DATA_W-1:0] v,
                                             input logic [TY_W-1:0] ty);
      logic s;
      logic [DATA_W-1:0] r;
      s = ~ty[2];
      unique case (ty[1:0])
         2'd0: r = {{56{s & v[7]}}, v[7:0]};
         2'd1: r = {{48{s & v[15]}}, v[15:0]};
         2'd2: r = {{32{s & v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tai_if.sv -----
// Handshake channels of the typed integer ALU: request and response.
// Depends on tai_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tai_req_if;
   logic                          valid;
   logic                          ready;
   logic [tai_pkg::CMD_W-1:0]     command;
   logic [tai_pkg::TY_W-1:0]      operand_type;
   logic [tai_pkg::DATA_W-1:0]    operand_a;
   logic [tai_pkg::DATA_W-1:0]    operand_b;
   logic [tai_pkg::TGT_W-1:0]     target_type;
   modport source (output valid, command, operand_type, operand_a, operand_b,
                   target_type, input ready);
   modport sink (input valid, command, operand_type, operand_a, operand_b,
                 target_type, output ready);
endinterface

interface tai_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tai_pkg::DATA_W-1:0]    result_value;
   logic [tai_pkg::ERR_W-1:0]     error_code;
   modport source (output valid, result_value, error_code, input ready);
   modport sink (input valid, result_value, error_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/typed_integer_alu.sv -----
// Top level of the typed integer ALU: front, queue and back joined.
// Depends on tai_pkg, tai_if, tai_front, tai_back, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Takes one beat per cycle while the front queue has room and returns one
// response beat per request, in order. Every instruction runs through the
// same pipeline: the front queue, a register for operand preparation and
// the partial products of the split 64-bit multiplier, 64 divider stages
// (one quotient bit each) and the response register. Back-pressure on the
// response stalls the whole back pipeline; the front queue of QueueDepth
// beats lets requests keep arriving meanwhile.
module typed_integer_alu #(
   parameter int QueueDepth = tai_pkg::QUEUE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   tai_req_if.sink   req_bus,
   tai_rsp_if.source rsp_bus
);
   tai_pkg::op_type head;
   logic head_valid, head_pop;

   tai_front #(.QueueDepth(QueueDepth)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus),
      .head(head), .head_valid(head_valid), .head_pop(head_pop)
   );

   tai_back u_back (
      .clock(clock), .reset(reset), .head(head), .head_valid(head_valid),
      .head_pop(head_pop), .rsp_bus(rsp_bus)
   );

   `TAI_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_bus.valid)
   `TAI_ASSERT_IMPL(a_err_zero, clock, reset,
      rsp_bus.valid && rsp_bus.error_code != tai_pkg::ERR_NONE,
      rsp_bus.result_value == '0)
   `TAI_ASSERT_IMPL(a_pop_needs_data, clock, reset, head_pop, head_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/tai_front.sv -----
// Front part: fits operands, settles the simple operations and
// classifies the rest, then queues the beat. Depends on tai_pkg, tai_if.
`timescale 1ns / 1ps
`default_nettype none

module tai_front #(
   parameter int QueueDepth = tai_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   tai_req_if.sink         req_bus,
   output tai_pkg::op_type head,
   output logic            head_valid,
   input  wire logic       head_pop
);
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   tai_pkg::op_type op;
   logic [tai_pkg::DATA_W-1:0] a, b, sa, sb, shl_v, shr_v;
   logic [31:0] cnt;
   logic sgn, wide, lt_ab, lt_ba;

   tai_pkg::op_type queue_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push;

   function automatic logic [tai_pkg::DATA_W-1:0] DATA_W_SHR(
      input logic [tai_pkg::DATA_W-1:0] v, input logic [5:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

   always_comb begin
      sgn = tai_pkg::ty_signed(req_bus.operand_type);
      a = tai_pkg::fit(req_bus.operand_a, req_bus.operand_type);
      b = tai_pkg::fit(req_bus.operand_b, req_bus.operand_type);
      wide = (req_bus.operand_type[1:0] == 2'd3);
      cnt = b[31:0];
      sa = {a[63] ^ sgn, a[62:0]};
      sb = {b[63] ^ sgn, b[62:0]};
      lt_ab = sa < sb;
      lt_ba = sb < sa;
      shl_v = a << cnt[5:0];
      shr_v = sgn ? DATA_W_SHR(a, cnt[5:0]) : (a >> cnt[5:0]);
      op.cmd = req_bus.command;
      op.ty = req_bus.operand_type;
      op.kind = tai_pkg::KIND_SIMPLE;
      op.err = tai_pkg::ERR_NONE;
      op.a = a;
      op.b = b;
      op.res = '0;
      unique case (req_bus.command)
         tai_pkg::CMD_ADD: op.res = tai_pkg::fit(a + b, req_bus.operand_type);
         tai_pkg::CMD_SUB: op.res = tai_pkg::fit(a - b, req_bus.operand_type);
         tai_pkg::CMD_MUL: op.kind = tai_pkg::KIND_MUL;
         tai_pkg::CMD_DIV, tai_pkg::CMD_REM: begin
            op.kind = tai_pkg::KIND_DIV;
            if (b == '0) op.err = tai_pkg::ERR_DIV_ZERO;
         end
         tai_pkg::CMD_AND: op.res = a & b;
         tai_pkg::CMD_OR: op.res = a | b;
         tai_pkg::CMD_XOR: op.res = a ^ b;
         tai_pkg::CMD_SHL, tai_pkg::CMD_SHR: begin
            if (cnt >= (wide ? 32'd64 : 32'd32)) begin
               op.err = tai_pkg::ERR_SHIFT;
            end else begin
               op.res = tai_pkg::fit((req_bus.command == tai_pkg::CMD_SHL) ? shl_v : shr_v,
                                     req_bus.operand_type);
            end
         end
         tai_pkg::CMD_EQ: op.res = (a == b) ? tai_pkg::CMP_TRUE : tai_pkg::CMP_FALSE;
         tai_pkg::CMD_GT: op.res = lt_ba ? tai_pkg::CMP_TRUE : tai_pkg::CMP_FALSE;
         tai_pkg::CMD_GE: op.res = lt_ab ? tai_pkg::CMP_FALSE : tai_pkg::CMP_TRUE;
         tai_pkg::CMD_NE: op.res = (a != b) ? tai_pkg::CMP_TRUE : tai_pkg::CMP_FALSE;
         tai_pkg::CMD_CAST: begin
            if (!req_bus.target_type[3]) begin
               op.res = tai_pkg::fit(a, req_bus.target_type[2:0]);
            end else if (req_bus.target_type == tai_pkg::TGT_PTR) begin
               op.res = {32'd0, a[31:0]};
            end else begin
               op.err = tai_pkg::ERR_CAST;
            end
         end
         default: op.err = tai_pkg::ERR_CAST;
      endcase
   end

   assign req_bus.ready = (count_ff != CntW'(QueueDepth));
   assign push = req_bus.valid && req_bus.ready;
   assign head = queue_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (head_pop) rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CntW'(push) - CntW'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= op;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tai_back.sv -----
// Back part: split multiplier and a one-bit-per-stage divider pipeline,
// ending in the response register. Depends on tai_pkg, tai_if.
`timescale 1ns / 1ps
`default_nettype none

module tai_back (
   input  wire logic       clock,
   input  wire logic       reset,
   input  tai_pkg::op_type head,
   input  wire logic       head_valid,
   output logic            head_pop,
   tai_rsp_if.source       rsp_bus
);
   localparam int W = tai_pkg::DATA_W;
   localparam int Steps = tai_pkg::DATA_W;

   typedef struct packed {
      tai_pkg::op_type  op;
      logic             q_neg;
      logic             r_neg;
      logic [W-1:0]     rem;
      logic [W-1:0]     quo;
      logic [W-1:0]     dvs;
   } stage_type;

   stage_type stg_ff [Steps+1];
   stage_type stg_in [Steps+1];
   logic      vld_ff [Steps+1];
   logic [W-1:0]  p_ll_ff;
   logic [31:0]   p_lh_ff, p_hl_ff;
   logic          adv;
   logic          out_valid_ff;
   logic [W-1:0]  out_res_ff, out_res_in;
   logic [tai_pkg::ERR_W-1:0] out_err_ff;

   // The whole pipeline moves together whenever the response slot frees.
   assign adv = !out_valid_ff || rsp_bus.ready;
   assign head_pop = adv && head_valid;

   always_comb begin
      logic na, nb;
      na = tai_pkg::ty_signed(head.ty) && head.a[W-1];
      nb = tai_pkg::ty_signed(head.ty) && head.b[W-1];
      stg_in[0].op = head;
      stg_in[0].q_neg = na ^ nb;
      stg_in[0].r_neg = na;
      stg_in[0].rem = '0;
      stg_in[0].quo = na ? (W'(0) - head.a) : head.a;
      stg_in[0].dvs = nb ? (W'(0) - head.b) : head.b;
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_comb begin
         logic [W:0] trial;
         stg_in[i+1] = stg_ff[i];
         trial = {stg_ff[i].rem, stg_ff[i].quo[W-1]} - {1'b0, stg_ff[i].dvs};
         if (!trial[W]) begin
            stg_in[i+1].rem = trial[W-1:0];
            stg_in[i+1].quo = {stg_ff[i].quo[W-2:0], 1'b1};
         end else begin
            stg_in[i+1].rem = {stg_ff[i].rem[W-2:0], stg_ff[i].quo[W-1]};
            stg_in[i+1].quo = {stg_ff[i].quo[W-2:0], 1'b0};
         end
         if (i == 0 && stg_ff[i].op.kind == tai_pkg::KIND_MUL) begin
            stg_in[i+1].op.res = tai_pkg::fit(p_ll_ff + {p_lh_ff + p_hl_ff, 32'd0},
                                              stg_ff[i].op.ty);
         end
      end
   end

   for (genvar i = 0; i <= Steps; i++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= (i == 0) ? head_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) stg_ff[i] <= stg_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ll_ff <= head.a[31:0] * head.b[31:0];
         p_lh_ff <= 32'(head.a[31:0] * head.b[63:32]);
         p_hl_ff <= 32'(head.a[63:32] * head.b[31:0]);
      end
   end

   always_comb begin
      logic [W-1:0] q, r;
      q = stg_ff[Steps].q_neg ? (W'(0) - stg_ff[Steps].quo) : stg_ff[Steps].quo;
      r = stg_ff[Steps].r_neg ? (W'(0) - stg_ff[Steps].rem) : stg_ff[Steps].rem;
      if (stg_ff[Steps].op.err != tai_pkg::ERR_NONE) begin
         out_res_in = '0;
      end else if (stg_ff[Steps].op.kind == tai_pkg::KIND_DIV) begin
         out_res_in = tai_pkg::fit((stg_ff[Steps].op.cmd == tai_pkg::CMD_DIV) ? q : r,
                                   stg_ff[Steps].op.ty);
      end else begin
         out_res_in = stg_ff[Steps].op.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vld_ff[Steps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_res_ff <= out_res_in;
         out_err_ff <= stg_ff[Steps].op.err;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.result_value = out_res_ff;
   assign rsp_bus.error_code = out_err_ff;

endmodule

`default_nettype wire
